@@ design/ctcr_pkg.sv @@
`default_nettype none
package ctcr_pkg;

  // Highest pixel level, also the input level of the last fixed point.
  localparam int unsigned TopLevel = 255;

  // Configuration register indexes.
  localparam logic [7:0] IDX_P1_IN  = 8'd0;
  localparam logic [7:0] IDX_P1_OUT = 8'd1;
  localparam logic [7:0] IDX_P2_IN  = 8'd2;
  localparam logic [7:0] IDX_P2_OUT = 8'd3;

  typedef struct packed {
    logic [7:0] p1_in;
    logic [7:0] p1_out;
    logic [7:0] p2_in;
    logic [7:0] p2_out;
  } pt_cfg_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  // One queue entry between the front and the back.
  typedef struct packed {
    pix_t pix;
    logic bad;
  } qent_t;

  // Table write from the curve builder.
  typedef struct packed {
    logic       en;
    logic [7:0] addr;
    logic [7:0] data;
  } tbl_wr_t;

endpackage
`default_nettype wire

@@ design/ctcr_ifs.sv @@
`default_nettype none
// Pixel input channel.
interface ctcr_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, output in_red, output in_green, output in_blue, input ready);
  modport sink (input valid, input in_red, input in_green, input in_blue, output ready);
endinterface

// Result output channel.
interface ctcr_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       bad_points;
  modport source (output valid, output out_red, output out_green, output out_blue,
                  output bad_points, input ready);
  modport sink (input valid, input out_red, input out_green, input out_blue,
                input bad_points, output ready);
endinterface

// Configuration write channel.
interface ctcr_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ design/ctcr_ram.sv @@
`default_nettype none
module ctcr_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [Width-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  // One write port, one registered read port that holds when not enabled.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

@@ design/ctcr_build.sv @@
`default_nettype none
module ctcr_build
  import ctcr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    restart,
  input  wire pt_cfg_t cfg,
  output tbl_wr_t      wr,
  output logic         busy
);

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_DIVINIT, S_DIV, S_WRITE} state_t;

  // Term codes; TERM_DEN is the common denominator, computed once per build.
  localparam logic [1:0] TERM_P   = 2'd0;
  localparam logic [1:0] TERM_Q   = 2'd1;
  localparam logic [1:0] TERM_TOP = 2'd2;
  localparam logic [1:0] TERM_DEN = 2'd3;

  state_t             state;
  logic [1:0]         term;
  logic [2:0]         fidx;
  logic [7:0]         x;
  logic signed [63:0] acc;
  logic signed [63:0] num;
  logic signed [63:0] den;
  logic [63:0]        rem;
  logic [63:0]        dsh;
  logic [63:0]        dabs;
  logic [7:0]         quo;
  logic [2:0]         step;

  logic signed [9:0]  va, vb, vp, vq, vx, vt;
  logic signed [9:0]  f;
  logic signed [73:0] prod;
  logic               last;
  logic [63:0]        absn;
  logic [63:0]        absd;
  logic               neg;
  logic               ge;

  assign va = signed'({2'b00, cfg.p1_in});
  assign vp = signed'({2'b00, cfg.p1_out});
  assign vb = signed'({2'b00, cfg.p2_in});
  assign vq = signed'({2'b00, cfg.p2_out});
  assign vx = signed'({2'b00, x});
  assign vt = signed'(10'(TopLevel));

  // Factor list of each Lagrange term, one factor per multiply cycle.
  always_comb begin
    f = vt;
    unique case (term)
      TERM_P: begin
        unique case (fidx)
          3'd0: f = vp;
          3'd1: f = vx;
          3'd2: f = vx - vb;
          3'd3: f = vx - vt;
          3'd4: f = vb;
          3'd5: f = vb - vt;
          default: f = vt;
        endcase
      end
      TERM_Q: begin
        unique case (fidx)
          3'd0: f = vq;
          3'd1: f = vx;
          3'd2: f = vx - va;
          3'd3: f = vx - vt;
          3'd4: f = va;
          3'd5: f = va - vt;
          default: f = vt;
        endcase
      end
      TERM_TOP: begin
        unique case (fidx)
          3'd0: f = vt;
          3'd1: f = vx;
          3'd2: f = vx - va;
          3'd3: f = vx - vb;
          3'd4: f = va;
          3'd5: f = vb;
          default: f = va - vb;
        endcase
      end
      default: begin
        unique case (fidx)
          3'd0: f = va;
          3'd1: f = vb;
          3'd2: f = va - vb;
          3'd3: f = va - vt;
          3'd4: f = vb - vt;
          default: f = vt;
        endcase
      end
    endcase
  end

  assign prod = acc * f;
  assign last = (term == TERM_DEN) ? (fidx == 3'd5) : (fidx == 3'd6);

  // Magnitudes and quotient sign for the truncating division.
  assign absn = num[63] ? 64'(-num) : 64'(num);
  assign absd = den[63] ? 64'(-den) : 64'(den);
  assign neg  = num[63] ^ den[63];
  assign ge   = (rem >= dsh);

  // Build sequencer: denominator, then per level three terms and a division.
  always_ff @(posedge clk) begin
    if (rst || restart) begin
      state <= S_MUL;
      term  <= TERM_DEN;
      fidx  <= 3'd0;
      acc   <= 64'sd1;
      x     <= 8'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
        end
        S_MUL: begin
          if (last) begin
            fidx <= 3'd0;
            acc  <= 64'sd1;
            unique case (term)
              TERM_DEN: begin
                den  <= prod[63:0];
                term <= TERM_P;
              end
              TERM_P: begin
                num  <= prod[63:0];
                term <= TERM_Q;
              end
              TERM_Q: begin
                num  <= num - prod[63:0];
                term <= TERM_TOP;
              end
              default: begin
                num   <= num + prod[63:0];
                state <= S_DIVINIT;
              end
            endcase
          end else begin
            acc  <= prod[63:0];
            fidx <= fidx + 3'd1;
          end
        end
        S_DIVINIT: begin
          rem  <= absn;
          dabs <= absd;
          dsh  <= absd << 7;
          step <= 3'd7;
          quo  <= 8'd0;
          if (neg) begin
            state <= S_WRITE;
          end else if (absn >= (absd << 8)) begin
            quo   <= 8'd255;
            state <= S_WRITE;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (ge) begin
            rem <= rem - dsh;
          end
          quo  <= {quo[6:0], ge};
          dsh  <= dsh >> 1;
          step <= step - 3'd1;
          if (step == 3'd0) begin
            state <= S_WRITE;
          end
        end
        default: begin
          if (x == 8'(TopLevel)) begin
            state <= S_IDLE;
          end else begin
            x     <= x + 8'd1;
            term  <= TERM_P;
            fidx  <= 3'd0;
            acc   <= 64'sd1;
            state <= S_MUL;
          end
        end
      endcase
    end
  end

  assign wr.en   = (state == S_WRITE);
  assign wr.addr = x;
  assign wr.data = quo;
  assign busy    = (state != S_IDLE);

  // The build finishes only after writing the last level.
  a_done_at_top: assert property (@(posedge clk) disable iff (rst || restart)
    $fell(busy) |-> $past(x) == 8'(TopLevel))
    else $error("table build ended before the last level");

  // The shifted divisor never exceeds the divisor times 128 while dividing.
  a_dsh_bound: assert property (@(posedge clk) disable iff (rst || restart)
    state == S_DIV |-> dsh <= (dabs << 7))
    else $error("division shift out of range");

endmodule
`default_nettype wire

@@ design/ctcr_front.sv @@
`default_nettype none
module ctcr_front
  import ctcr_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  ctcr_pix_if.sink     pix,
  input  wire pt_cfg_t cfg,
  input  wire logic    busy,
  output qent_t        q_data,
  output logic         q_valid,
  input  wire logic    q_pop
);

  qent_t      mem [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;
  logic       bad;

  // Two middle points that share a level with each other or an end point.
  assign bad = (cfg.p1_in == 8'd0) || (cfg.p2_in == 8'd0) ||
               (cfg.p1_in == 8'(TopLevel)) || (cfg.p2_in == 8'(TopLevel)) ||
               (cfg.p1_in == cfg.p2_in);

  assign pix.ready = !busy && (count != 2'd2);
  assign push      = pix.valid && pix.ready;
  assign q_valid   = (count != 2'd0);
  assign q_data    = mem[rptr];

  // Queue payload.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= '{pix: '{r: pix.in_red, g: pix.in_green, b: pix.in_blue}, bad: bad};
    end
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= !wptr;
      end
      if (q_pop) begin
        rptr <= !rptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("pixel queue overflow");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != 2'd0)
    else $error("pop from empty pixel queue");

endmodule
`default_nettype wire

@@ design/ctcr_back.sv @@
`default_nettype none
module ctcr_back
  import ctcr_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire qent_t      q_data,
  input  wire logic       q_valid,
  output logic            q_pop,
  output logic            re,
  output pix_t            raddr,
  input  wire logic [7:0] rd_r,
  input  wire logic [7:0] rd_g,
  input  wire logic [7:0] rd_b,
  ctcr_res_if.source      res
);

  logic s1_valid;
  logic s1_bad;
  logic out_valid;
  logic s1_load;
  logic out_load;

  // Table read stage, then the output register; the read data holds while stalled.
  assign out_load = s1_valid && (!out_valid || res.ready);
  assign s1_load  = !s1_valid || out_load;
  assign q_pop    = s1_load && q_valid;
  assign re       = q_pop;
  assign raddr    = q_data.pix;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= q_valid;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (q_pop) begin
      s1_bad <= q_data.bad;
    end
    if (out_load) begin
      res.out_red    <= s1_bad ? 8'd0 : rd_r;
      res.out_green  <= s1_bad ? 8'd0 : rd_g;
      res.out_blue   <= s1_bad ? 8'd0 : rd_b;
      res.bad_points <= s1_bad;
    end
  end

  assign res.valid = out_valid;

  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    res.valid && res.bad_points |->
      res.out_red == 8'd0 && res.out_green == 8'd0 && res.out_blue == 8'd0)
    else $error("singular points gave a nonzero result");

endmodule
`default_nettype wire

@@ design/cubic_tone_curve_rgb_unit.sv @@
`default_nettype none
// Cubic tone curve for RGB pixels. Each channel is mapped through the cubic
// that passes through (0,0), (point1_in,point1_out), (point2_in,point2_out)
// and (255,255), with the quotient truncated toward zero and clamped to
// 0..255. The curve is held in a 256-entry table per channel that a
// multiply-and-divide sequencer fills after reset and after every
// configuration write; the pixel input is not ready while it runs. The fill
// computes the common denominator once, then for each of the 256 levels
// three product terms, a setup step, a division of up to 8 quotient bits
// and one table write. Once filled, the block takes one pixel per clock
// while the result output is not stalled, limited by the single read port
// of each table; a pixel passes a two-entry queue, the table read and the
// output register. When the middle points share a level with each other or
// with an end point, every result has bad_points set and zero channels.
module cubic_tone_curve_rgb_unit
  import ctcr_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  ctcr_pix_if.sink   pix,
  ctcr_res_if.source res,
  ctcr_cfg_if.sink   cfg
);

  pt_cfg_t pts;
  tbl_wr_t wr;
  logic    busy;
  logic    restart;
  qent_t   q_data;
  logic    q_valid;
  logic    q_pop;
  logic    re;
  pix_t    raddr;
  logic [7:0] rd_r, rd_g, rd_b;

  assign cfg.ready = 1'b1;
  assign restart   = cfg.valid && cfg.ready;

  // Control point registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      pts.p1_in  <= 8'd64;
      pts.p1_out <= 8'd64;
      pts.p2_in  <= 8'd192;
      pts.p2_out <= 8'd192;
    end else if (restart) begin
      unique case (cfg.index)
        IDX_P1_IN:  pts.p1_in  <= cfg.data;
        IDX_P1_OUT: pts.p1_out <= cfg.data;
        IDX_P2_IN:  pts.p2_in  <= cfg.data;
        IDX_P2_OUT: pts.p2_out <= cfg.data;
        default: begin
        end
      endcase
    end
  end

  ctcr_build u_build (
    .clk(clk), .rst(rst), .restart(restart), .cfg(pts), .wr(wr), .busy(busy)
  );

  ctcr_front u_front (
    .clk(clk), .rst(rst), .pix(pix), .cfg(pts), .busy(busy),
    .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop)
  );

  // One curve table per channel, all written with the same contents.
  ctcr_ram #(.Width(8), .Depth(256)) u_ram_r (
    .clk(clk), .we(wr.en), .waddr(wr.addr), .wdata(wr.data),
    .re(re), .raddr(raddr.r), .rdata(rd_r)
  );
  ctcr_ram #(.Width(8), .Depth(256)) u_ram_g (
    .clk(clk), .we(wr.en), .waddr(wr.addr), .wdata(wr.data),
    .re(re), .raddr(raddr.g), .rdata(rd_g)
  );
  ctcr_ram #(.Width(8), .Depth(256)) u_ram_b (
    .clk(clk), .we(wr.en), .waddr(wr.addr), .wdata(wr.data),
    .re(re), .raddr(raddr.b), .rdata(rd_b)
  );

  ctcr_back u_back (
    .clk(clk), .rst(rst), .q_data(q_data), .q_valid(q_valid), .q_pop(q_pop),
    .re(re), .raddr(raddr), .rd_r(rd_r), .rd_g(rd_g), .rd_b(rd_b), .res(res)
  );

  a_no_accept_building: assert property (@(posedge clk) disable iff (rst)
    busy |-> !pix.ready)
    else $error("pixel accepted while the curve table is being built");

endmodule
`default_nettype wire
